// File: rtl/core/ray_box_slab_test_macros.svh
// assertion macros for the ray box slab test block
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while in reset
`define RBST_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rbst assertion failed");
// checked property, also active during reset
`define RBST_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rbst reset assertion failed");
`else
`define RBST_ASSERT(label, prop)
`define RBST_ASSERT_RST(label, prop)
`endif
`endif

// File: rtl/core/rbst_pkg.sv
// types shared by the ray box slab test pipeline
`timescale 1ns / 1ps
package rbst_pkg;
    localparam int unsigned FieldWidth = 32;
    localparam int unsigned NumWidth = FieldWidth + 1;
    localparam int unsigned ProdWidth = 2 * NumWidth;

    // exact time as numerator over positive denominator
    typedef struct packed {
        logic signed [NumWidth-1:0] n;
        logic [FieldWidth-1:0] d;
    } frac_t;

    // entry/exit interval, v low means no limit
    typedef struct packed {
        logic v;
        frac_t lo;
        frac_t hi;
    } span_t;

    typedef struct packed {
        span_t span;
        logic in_box;
        logic pmiss;
    } axis_t;

    typedef struct packed {
        logic in_box;
        logic miss;
    } flags_t;
endpackage

// File: rtl/core/rbst_axis.sv
// per-axis slab prep: offsets, sign fold, entry/exit ordering (two stages)
`timescale 1ns / 1ps
module rbst_axis (
    input  logic aclk,
    input  logic adv,
    input  logic signed [rbst_pkg::FieldWidth-1:0] lo,
    input  logic signed [rbst_pkg::FieldWidth-1:0] hi,
    input  logic signed [rbst_pkg::FieldWidth-1:0] org,
    input  logic signed [rbst_pkg::FieldWidth-1:0] dir,
    output rbst_pkg::axis_t axis_out
);
    import rbst_pkg::*;

    logic signed [NumWidth-1:0] na_reg, na_next, nb_reg, nb_next;
    logic [FieldWidth-1:0] dabs_reg, dabs_next;
    logic neg_reg, zero_reg, inside_reg, pmiss_reg;
    logic zero_next, inside_next, pmiss_next;
    logic [NumWidth-1:0] dneg;
    axis_t out_reg, out_next;
    logic signed [NumWidth-1:0] fa, fb;

    always_comb begin
        na_next = NumWidth'(lo) - NumWidth'(org);
        nb_next = NumWidth'(hi) - NumWidth'(org);
        dneg = -{dir[FieldWidth-1], dir};
        dabs_next = dir[FieldWidth-1] ? dneg[FieldWidth-1:0] : dir;
        zero_next = (dir == '0);
        inside_next = (lo < org) && (org < hi);
        pmiss_next = zero_next && !(((org >= lo) && (org <= hi)) ||
                                    ((org >= hi) && (org <= lo)));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            na_reg <= na_next;
            nb_reg <= nb_next;
            dabs_reg <= dabs_next;
            neg_reg <= dir[FieldWidth-1];
            zero_reg <= zero_next;
            inside_reg <= inside_next;
            pmiss_reg <= pmiss_next;
        end
    end

    always_comb begin
        fa = neg_reg ? -na_reg : na_reg;
        fb = neg_reg ? -nb_reg : nb_reg;
        out_next.span.v = !zero_reg;
        out_next.span.lo.n = (fa < fb) ? fa : fb;
        out_next.span.hi.n = (fa < fb) ? fb : fa;
        out_next.span.lo.d = dabs_reg;
        out_next.span.hi.d = dabs_reg;
        out_next.in_box = inside_reg;
        out_next.pmiss = pmiss_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign axis_out = out_reg;
endmodule

// File: rtl/core/rbst_merge.sv
// intersect two intervals: cross products, then compare and select
`timescale 1ns / 1ps
module rbst_merge (
    input  logic aclk,
    input  logic adv,
    input  rbst_pkg::span_t a,
    input  rbst_pkg::span_t b,
    output rbst_pkg::span_t y
);
    import rbst_pkg::*;

    logic signed [ProdWidth-1:0] pna_reg, pnb_reg, pfa_reg, pfb_reg;
    span_t a_reg, b_reg, y_reg, y_next;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pna_reg <= a.lo.n * $signed({1'b0, b.lo.d});
            pnb_reg <= b.lo.n * $signed({1'b0, a.lo.d});
            pfa_reg <= a.hi.n * $signed({1'b0, b.hi.d});
            pfb_reg <= b.hi.n * $signed({1'b0, a.hi.d});
            a_reg <= a;
            b_reg <= b;
        end
    end

    always_comb begin
        if (!a_reg.v) begin
            y_next = b_reg;
        end else if (!b_reg.v) begin
            y_next = a_reg;
        end else begin
            y_next.v = 1'b1;
            // near is the later entry, far the earlier exit
            y_next.lo = (pna_reg < pnb_reg) ? b_reg.lo : a_reg.lo;
            y_next.hi = (pfb_reg < pfa_reg) ? b_reg.hi : a_reg.hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;
endmodule

// File: rtl/core/ray_box_slab_test.sv
// top level of the ray versus axis-aligned box slab test pipeline
//
// usage:
//   input channel s_*: one item is a box (min/max corners) and a ray
//   (origin, direction), all signed q16.16; taken when s_valid && s_ready
//   result channel m_*: one item per input, m_hit, taken when
//   m_valid && m_ready
//   pipeline: accept to m_valid passes 2 axis prep stages, two
//   interval merges of 2 stages each, then final cross product and compare
//   throughput: one item per cycle unless stalled; every stage is a registered step of
//   33x33 multiplies or wide subtracts/compares
//   stall: the whole pipeline freezes while m_valid is high and m_ready low;
//   s_ready drops in the same cycle so nothing is lost or repeated
//   reset: synchronous active-low aresetn clears all stage valid bits
//   zero direction component: that axis sets no limit if the origin lies
//   within its slab, otherwise the item is a miss
`timescale 1ns / 1ps
`include "ray_box_slab_test_macros.svh"
module ray_box_slab_test (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_min_x,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_min_y,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_min_z,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_max_x,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_max_y,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_box_max_z,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_origin_x,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_origin_y,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_origin_z,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_dir_x,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_dir_y,
    input  logic signed [rbst_pkg::FieldWidth-1:0] s_dir_z,
    output logic m_valid,
    input  logic m_ready,
    output logic m_hit
);
    import rbst_pkg::*;

    localparam int unsigned Depth = 8;
    localparam int unsigned FlagDepth = 6;

    // global advance: pipeline moves unless the output item is stalled
    logic adv;
    logic [Depth-1:0] v_reg, v_next;
    flags_t flag_reg [FlagDepth], flag_next;
    axis_t ax_x, ax_y, ax_z;
    span_t z_d_reg [2];
    span_t xy, xyz;
    logic signed [ProdWidth-1:0] pfn_reg, pnn_reg;
    logic near_v_reg, near_pos_reg;
    logic hit_reg, hit_next;

    assign adv = !v_reg[Depth-1] || m_ready;
    assign s_ready = adv;

    rbst_axis u_axis_x (
        .aclk(aclk), .adv(adv), .lo(s_box_min_x), .hi(s_box_max_x),
        .org(s_origin_x), .dir(s_dir_x), .axis_out(ax_x)
    );
    rbst_axis u_axis_y (
        .aclk(aclk), .adv(adv), .lo(s_box_min_y), .hi(s_box_max_y),
        .org(s_origin_y), .dir(s_dir_y), .axis_out(ax_y)
    );
    rbst_axis u_axis_z (
        .aclk(aclk), .adv(adv), .lo(s_box_min_z), .hi(s_box_max_z),
        .org(s_origin_z), .dir(s_dir_z), .axis_out(ax_z)
    );

    // item valid bits travel alongside the data
    always_comb begin
        v_next = {v_reg[Depth-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= v_next;
        end
    end

    // inside-all-axes and any-parallel-miss, collected after axis prep
    always_comb begin
        flag_next.in_box = ax_x.in_box && ax_y.in_box && ax_z.in_box;
        flag_next.miss = ax_x.pmiss || ax_y.pmiss || ax_z.pmiss;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            flag_reg[0] <= flag_next;
            for (int i = 1; i < FlagDepth; i++) begin
                flag_reg[i] <= flag_reg[i-1];
            end
            // z axis waits for the x/y merge
            z_d_reg[0] <= ax_z.span;
            z_d_reg[1] <= z_d_reg[0];
        end
    end

    rbst_merge u_merge_xy (
        .aclk(aclk), .adv(adv), .a(ax_x.span), .b(ax_y.span), .y(xy)
    );
    rbst_merge u_merge_z (
        .aclk(aclk), .adv(adv), .a(xy), .b(z_d_reg[1]), .y(xyz)
    );

    // final check: near <= far via cross products, near not negative
    always_ff @(posedge aclk) begin
        if (adv) begin
            pfn_reg <= xyz.hi.n * $signed({1'b0, xyz.lo.d});
            pnn_reg <= xyz.lo.n * $signed({1'b0, xyz.hi.d});
            near_v_reg <= xyz.v;
            near_pos_reg <= !xyz.lo.n[NumWidth-1];
        end
    end

    always_comb begin
        hit_next = flag_reg[FlagDepth-2].in_box ||
                   (!flag_reg[FlagDepth-2].miss && near_v_reg && near_pos_reg &&
                    !(pfn_reg < pnn_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= hit_next;
        end
    end

    assign m_valid = v_reg[Depth-1];
    assign m_hit = hit_reg;

    `RBST_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid)
    `RBST_ASSERT(a_stall_freeze, (m_valid && !m_ready) |=> $stable(v_reg))
    `RBST_ASSERT(a_accept_enters, (s_valid && s_ready) |=> v_reg[0])
    `RBST_ASSERT(a_inside_hits, (m_valid && flag_reg[FlagDepth-1].in_box) |-> m_hit)
endmodule

// File: dv/tb.sv
// self-checking testbench for the ray versus box slab test pipeline
`timescale 1ns / 1ps

// expected hit flags in acceptance order, with mismatch bookkeeping
class hit_scoreboard;
    bit expected_hits[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits_seen;

    function void note_item(bit hit);
        expected_hits.push_back(hit);
    endfunction

    function void check_hit(bit actual);
        bit want;
        if (expected_hits.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("error: hit=%0b arrived with no item outstanding", actual);
            return;
        end
        want = expected_hits.pop_front();
        checked++;
        if (actual) hits_seen++;
        if (want != actual) begin
            errors++;
            if (errors <= 10)
                $display("error: result %0d hit expected %0b got %0b",
                         checked, want, actual);
        end
    endfunction
endclass

module tb;
    localparam int NumItems = 1800;
    localparam int StallLimit = 4000;
    localparam int Latency = 8;

    typedef logic signed [31:0] q16_t;

    // one ray/box query: index 0..2 = x,y,z
    typedef struct {
        q16_t bmin [3];
        q16_t bmax [3];
        q16_t org [3];
        q16_t dir [3];
    } query_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    q16_t s_box_min_x = '0, s_box_min_y = '0, s_box_min_z = '0;
    q16_t s_box_max_x = '0, s_box_max_y = '0, s_box_max_z = '0;
    q16_t s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    q16_t s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;

    hit_scoreboard sb = new();
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ray_box_slab_test DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_box_min_x(s_box_min_x), .s_box_min_y(s_box_min_y), .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x), .s_box_max_y(s_box_max_y), .s_box_max_z(s_box_max_z),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit)
    );

    // a/b < c/d with positive denominators, exact in 66 bits
    function automatic bit time_less(longint an, longint ad, longint bn, longint bd);
        logic signed [65:0] l, r;
        l = 66'(an) * 66'(bd);
        r = 66'(bn) * 66'(ad);
        return l < r;
    endfunction

    // exact slab test, times kept as fractions
    function automatic bit predict_hit(query_t q);
        bit in_box;
        bit limited;
        longint near_n, near_d, far_n, far_d;
        longint lo, hi, o, dn, na, nb, en, ex, tmp;
        in_box = 1'b1;
        limited = 1'b0;
        near_n = 0; near_d = 1; far_n = 0; far_d = 1;
        for (int a = 0; a < 3; a++)
            if (!(q.bmin[a] < q.org[a] && q.org[a] < q.bmax[a])) in_box = 1'b0;
        if (in_box) return 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo = q.bmin[a];
            hi = q.bmax[a];
            o = q.org[a];
            dn = q.dir[a];
            if (dn == 0) begin
                // parallel axis: origin must sit within the slab, ends included
                if (lo > hi) begin
                    tmp = lo; lo = hi; hi = tmp;
                end
                if (o < lo || o > hi) return 1'b0;
                continue;
            end
            na = lo - o;
            nb = hi - o;
            if (dn < 0) begin
                na = -na; nb = -nb; dn = -dn;
            end
            en = (na < nb) ? na : nb;
            ex = (na < nb) ? nb : na;
            if (!limited) begin
                near_n = en; near_d = dn; far_n = ex; far_d = dn;
                limited = 1'b1;
            end else begin
                if (time_less(near_n, near_d, en, dn)) begin
                    near_n = en; near_d = dn;
                end
                if (time_less(ex, dn, far_n, far_d)) begin
                    far_n = ex; far_d = dn;
                end
            end
        end
        if (!limited) return 1'b0;
        return near_n >= 0 && !time_less(far_n, far_d, near_n, near_d);
    endfunction

    function automatic q16_t rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return q16_t'($urandom_range(0, 7)) - 3;
            default: return q16_t'($urandom());
        endcase
    endfunction

    function automatic q16_t rand_coord();
        return q16_t'($signed($urandom_range(0, 32'h00140000)) - 32'sh000a0000);
    endfunction

    // mostly well-formed boxes near the origin, rays aimed at or near them
    function automatic query_t rand_query();
        query_t q;
        int mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            if (mode == 0) begin
                q.bmin[a] = rand_word(); q.bmax[a] = rand_word();
                q.org[a] = rand_word(); q.dir[a] = rand_word();
            end else begin
                q.bmin[a] = rand_coord();
                q.bmax[a] = q.bmin[a] + q16_t'($urandom_range(0, 32'h00080000));
                if (mode == 1) q.bmax[a] = q.bmin[a] - q16_t'($urandom_range(0, 32'h40000));
                q.org[a] = rand_coord();
                case ($urandom_range(0, 7))
                    0: q.dir[a] = '0;
                    1: q.org[a] = q.bmin[a];
                    2: q.org[a] = q.bmax[a];
                    default: ;
                endcase
                // aim toward the box center with some jitter
                q.dir[a] = ($urandom_range(0, 7) == 0) ? '0 :
                    ((q.bmin[a] >>> 1) + (q.bmax[a] >>> 1) - q.org[a])
                    + q16_t'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
                if ($urandom_range(0, 15) == 0) q.dir[a] = rand_word();
            end
        end
        return q;
    endfunction

    function automatic query_t make_query(q16_t mn, q16_t mx, q16_t o, q16_t d);
        query_t q;
        for (int a = 0; a < 3; a++) begin
            q.bmin[a] = mn; q.bmax[a] = mx; q.org[a] = o; q.dir[a] = d;
        end
        return q;
    endfunction

    // offer one item after a random gap and wait for acceptance
    task automatic send_query(query_t q);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (sent % 200 < 40) gap = 0;
        // valid drops only for a gap; back-to-back items keep it high
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_box_min_x <= q.bmin[0]; s_box_min_y <= q.bmin[1]; s_box_min_z <= q.bmin[2];
        s_box_max_x <= q.bmax[0]; s_box_max_y <= q.bmax[1]; s_box_max_z <= q.bmax[2];
        s_origin_x <= q.org[0]; s_origin_y <= q.org[1]; s_origin_z <= q.org[2];
        s_dir_x <= q.dir[0]; s_dir_y <= q.dir[1]; s_dir_z <= q.dir[2];
        do @(posedge aclk); while (!s_ready);
        sb.note_item(predict_hit(q));
        sent++;
    endtask

    initial begin
        query_t q;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: inside, faces, parallel, inverted, extremes
        send_query(make_query(-32'sh10000, 32'sh10000, 0, 32'sh10000));
        send_query(make_query(-32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000));
        send_query(make_query(-32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
        send_query(make_query(32'sh10000, -32'sh10000, 0, 32'sh10000));
        send_query(make_query(-32'sh10000, 32'sh10000, 0, 0));
        send_query(make_query(-32'sh10000, 32'sh10000, 32'sh20000, 0));
        send_query(make_query(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        send_query(make_query(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
        send_query(make_query(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000));
        send_query(make_query(32'sh80000000, 32'sh80000000, 32'sh7fffffff, -1));
        send_query(make_query(32'sh10000, 32'sh20000, 0, -32'sh10000));
        send_query(make_query(32'sh10000, 32'sh20000, -32'sh50000, 1));
        q = make_query(-32'sh10000, 32'sh10000, 0, 32'sh10000);
        q.org[0] = 32'sh30000; q.dir[0] = -32'sh10000; q.dir[1] = 0; q.dir[2] = 0;
        send_query(q);
        q.org[1] = 32'sh10000;
        send_query(q);
        q.org[2] = 32'sh70000;
        send_query(q);
        q = make_query(0, 32'sh10000, -32'sh10000, 32'sh10000);
        q.dir[2] = 32'sh00001;
        send_query(q);

        while (sent < NumItems) send_query(rand_query());
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, with one long hold-off to fill the pipeline
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            if (sent >= 300 && sent < 320 && !hold_off) begin
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (sent % 200 >= 100 && sent % 200 < 140) wait_cycles = 0;
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // check results at the edge they are taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_hit(m_hit);
    end

    // watchdog on cycles with no handshake, then the end of the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("timeout: %0d items sent, %0d checked", sent, sb.checked);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (sb.expected_hits.size() == 0);
        repeat (4 * Latency) @(posedge aclk);
        $display("covered %0d ray/box queries, %0d hits, incl. parallel, inverted and face cases",
                 sb.checked, sb.hits_seen);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rbst_pkg.sv
rtl/core/rbst_axis.sv
rtl/core/rbst_merge.sv
rtl/core/ray_box_slab_test.sv
dv/tb.sv
